/* hdl/pfa_pkg.sv */
// Shared widths, codes and constants for the partition fit allocator.
`default_nettype none

package pfa_pkg;

  // Fixed field widths of the item and result beats.
  localparam int BLOCK_IDX_W = 4;
  localparam int OUT_SIZE_W  = 16;
  localparam int STATUS_W    = 2;
  localparam int MODE_W      = 2;
  localparam int COUNT_W     = 5;
  localparam int CFG_DATA_W  = 5;

  // Operation codes carried in func.
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_ALLOC = 1'b1;

  // Placement policies. The unused code behaves as first fit.
  localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_LOADED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ALLOC   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOALLOC = 2'd2;

  // Configuration register indexes.
  localparam logic REG_FIT_MODE    = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  // Register reset values.
  localparam logic [MODE_W-1:0]  FIT_MODE_RESET    = FIT_FIRST;
  localparam logic [COUNT_W-1:0] BLOCK_COUNT_RESET = 5'd16;

endpackage

`default_nettype wire

/* hdl/pfa_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module pfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/pfa_fit_unit.sv */
// Shared subtract and compare unit that judges one scanned block per cycle.
`default_nettype none

module pfa_fit_unit #(
  parameter int SIZE_BITS = 16
) (
  input  wire logic [pfa_pkg::MODE_W-1:0] mode,
  input  wire logic [SIZE_BITS-1:0]       rem,
  input  wire logic [SIZE_BITS-1:0]       amt,
  input  wire logic                       found,
  input  wire logic [SIZE_BITS-1:0]       pick_left,
  output logic                            take,
  output logic      [SIZE_BITS-1:0]       left
);

  logic [SIZE_BITS:0] diff;
  logic               fits;

  // The borrow bit tells whether the block is too small for the request.
  assign diff = {1'b0, rem} - {1'b0, amt};
  assign fits = ~diff[SIZE_BITS];
  assign left = diff[SIZE_BITS-1:0];

  // Strict compares keep ties on the lowest index, which is scanned first.
  always_comb begin
    unique case (mode)
      pfa_pkg::FIT_BEST:  take = fits && (!found || (left < pick_left));
      pfa_pkg::FIT_WORST: take = fits && (!found || (left > pick_left));
      default:            take = fits && !found;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/partition_fit_allocator.sv */
// Top level of the partition fit allocator: sequencer, block table and result register.
//
// Usage. Items arrive on the in_* channel (valid/ready). A load beat (func 0)
// writes amount into block block_index; an index at or beyond NUM_BLOCKS writes
// nothing. An allocate beat (func 1) scans blocks 0 up to block_count-1 for one
// that holds amount, chosen by fit_mode (first, best or worst fit, ties to the
// lowest index), subtracts the request from it and reports the block.
// Every item yields exactly one result beat on the out_* channel.
// Timing. A load goes from acceptance straight to the hand-off state, which moves
// the result into the output register and raises out_valid. With limit being
// block_count capped at NUM_BLOCKS, a placed allocate issues limit table reads,
// judges the last read, closes the scan, writes back and hands off; a refused one
// skips the write-back. in_ready is high only while the sequencer idles, so the
// next item is taken in the cycle after the hand-off at the earliest, and no new
// item is taken before the last one has been handed off.
// Stalls. The next item is accepted while a result waits in the output register; an
// item that finishes while that beat is still pending holds until the receiver takes it.
// Reset. rst (synchronous) clears the sequencer, the output valid and the
// registers (fit_mode 0, block_count 16). The table is not cleared: a block must be
// loaded before a request scans it. cfg_* is always ready; write it only while idle.
`default_nettype none

module partition_fit_allocator #(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              func,
  input  wire logic [pfa_pkg::BLOCK_IDX_W-1:0]   block_index,
  input  wire logic [SIZE_BITS-1:0]              amount,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [pfa_pkg::STATUS_W-1:0]      status,
  output logic      [pfa_pkg::BLOCK_IDX_W-1:0]   chosen_block,
  output logic      [pfa_pkg::OUT_SIZE_W-1:0]    remaining_after,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic                              cfg_index,
  input  wire logic [pfa_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int IDX_BITS = $clog2(NUM_BLOCKS);
  localparam int CNT_BITS = $clog2(NUM_BLOCKS + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRITE = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;

  // Configuration registers.
  logic [pfa_pkg::MODE_W-1:0]  fit_mode;
  logic [pfa_pkg::COUNT_W-1:0] block_count;

  // Item context and scan state.
  logic [SIZE_BITS-1:0] amt;
  logic [CNT_BITS-1:0]  rd_ptr;
  logic [CNT_BITS-1:0]  limit;
  logic                 cmp_valid;
  logic [IDX_BITS-1:0]  cmp_idx;
  logic                 found;
  logic [IDX_BITS-1:0]  pick;
  logic [SIZE_BITS-1:0] pick_left;

  // Result waiting to be moved into the output register.
  logic [pfa_pkg::STATUS_W-1:0]    res_status;
  logic [pfa_pkg::BLOCK_IDX_W-1:0] res_chosen;
  logic [pfa_pkg::OUT_SIZE_W-1:0]  res_remaining;

  // Table and fit unit signals.
  logic                 ram_we;
  logic [IDX_BITS-1:0]  ram_waddr;
  logic [SIZE_BITS-1:0] ram_wdata;
  logic [SIZE_BITS-1:0] ram_rdata;
  logic                 take;
  logic [SIZE_BITS-1:0] left;

  logic in_fire;
  logic is_load;
  logic load_ok;
  logic issue;
  logic scan_end;
  logic out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign is_load   = (func == pfa_pkg::FUNC_LOAD);
  assign load_ok   = (int'(block_index) < NUM_BLOCKS);
  assign out_free  = !out_valid || out_ready;

  // Counts above the table size scan the whole table.
  assign limit = (int'(block_count) > NUM_BLOCKS) ? CNT_BITS'(NUM_BLOCKS)
                                                  : CNT_BITS'(block_count);

  // One table read is issued per scan cycle until limit is reached; its data is judged in the next cycle.
  assign issue    = (state == S_SCAN) && (rd_ptr < limit);
  assign scan_end = (state == S_SCAN) && !issue && !cmp_valid;

  // The write port serves loads at acceptance and allocations at write-back.
  assign ram_we    = (in_fire && is_load && load_ok) || (state == S_WRITE);
  assign ram_waddr = (state == S_WRITE) ? pick : IDX_BITS'(block_index);
  assign ram_wdata = (state == S_WRITE) ? pick_left : amount;

  pfa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (NUM_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_ptr[IDX_BITS-1:0]),
    .rdata (ram_rdata)
  );

  pfa_fit_unit #(
    .SIZE_BITS (SIZE_BITS)
  ) u_fit (
    .mode      (fit_mode),
    .rem       (ram_rdata),
    .amt       (amt),
    .found     (found),
    .pick_left (pick_left),
    .take      (take),
    .left      (left)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = is_load ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = found ? S_WRITE : S_DONE;
        end
      end
      S_WRITE: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      cmp_valid   <= 1'b0;
      found       <= 1'b0;
      rd_ptr      <= '0;
      fit_mode    <= pfa_pkg::FIT_MODE_RESET;
      block_count <= pfa_pkg::BLOCK_COUNT_RESET;
    end else begin
      state     <= state_next;
      cmp_valid <= issue;
      cmp_idx   <= rd_ptr[IDX_BITS-1:0];

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          pfa_pkg::REG_FIT_MODE:    fit_mode    <= cfg_data[pfa_pkg::MODE_W-1:0];
          pfa_pkg::REG_BLOCK_COUNT: block_count <= cfg_data;
          default:                  fit_mode    <= fit_mode;
        endcase
      end

      // A new beat is loaded as soon as the register is free; otherwise a taken
      // beat leaves the register empty.
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            amt    <= amount;
            found  <= 1'b0;
            rd_ptr <= '0;
            if (is_load) begin
              res_status    <= pfa_pkg::ST_LOADED;
              res_chosen    <= '0;
              res_remaining <= load_ok ? pfa_pkg::OUT_SIZE_W'(amount) : '0;
            end
          end
        end
        S_SCAN: begin
          if (issue) begin
            rd_ptr <= rd_ptr + CNT_BITS'(1);
          end
          if (cmp_valid && take) begin
            found     <= 1'b1;
            pick      <= cmp_idx;
            pick_left <= left;
          end
          if (scan_end) begin
            if (found) begin
              res_status    <= pfa_pkg::ST_ALLOC;
              res_chosen    <= pfa_pkg::BLOCK_IDX_W'(pick);
              res_remaining <= pfa_pkg::OUT_SIZE_W'(pick_left);
            end else begin
              res_status    <= pfa_pkg::ST_NOALLOC;
              res_chosen    <= '0;
              res_remaining <= '0;
            end
          end
        end
        S_WRITE: begin
          found <= found;
        end
        S_DONE: begin
          if (out_free) begin
            status          <= res_status;
            chosen_block    <= res_chosen;
            remaining_after <= res_remaining;
          end
        end
        default: begin
          found <= 1'b0;
        end
      endcase
    end
  end

  // Write-back only happens for a request that found a block.
  a_write_found : assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> found)
    else $error("write-back without a chosen block");

  // The read pointer never runs past the scan limit.
  a_ptr_bound : assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (rd_ptr <= limit))
    else $error("scan pointer past the limit");

  // Pending compares belong to the scan only.
  a_cmp_in_scan : assert property (@(posedge clk) disable iff (rst)
    cmp_valid |-> (state == S_SCAN))
    else $error("compare pending outside the scan");

  // A refused request reports no block and no size.
  a_noalloc_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == pfa_pkg::ST_NOALLOC))
      |-> ((chosen_block == '0) && (remaining_after == '0)))
    else $error("refused request carries a block or size");

  // An accepted item moves the sequencer on to the scan or the done state.
  a_accept_idle : assert property (@(posedge clk) disable iff (rst)
    in_fire |=> ((state == S_SCAN) || (state == S_DONE)))
    else $error("accepted item did not start its sequence");

endmodule

`default_nettype wire
